// ===== design/chi_pkg.sv =====
// cubic hermite interpolator package: default word format and status codes
// used by chi_div and cubic_hermite_interpolator_core, no dependencies
package chi_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_ZERO_SPAN = 2'd1,
    STATUS_SAT       = 2'd2
  } status_t;

endpackage

// ===== design/chi_div.sv =====
// pipelined signed fixed-point divider, one quotient bit per register stage,
// rounded to nearest and saturated; parameter defaults from chi_pkg
module chi_div #(
  parameter int WORD_BITS = chi_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = chi_pkg::FRAC_BITS_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        ce,
  input  logic                        in_valid,
  input  logic signed [WORD_BITS-1:0] num,
  input  logic signed [WORD_BITS-1:0] den,
  input  logic [SIDE_BITS-1:0]        side_in,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] quo,
  output logic                        sat,
  output logic [SIDE_BITS-1:0]        side_out
);

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int QW = W + F;
  localparam logic [QW-1:0] LIM_P = {{(F + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [QW-1:0] LIM_N = LIM_P + 1'b1;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};

  function automatic logic [W-1:0] f_mag(input logic signed [W-1:0] a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  // x holds the partial remainder above the shifting numerator / quotient
  logic [W+QW-1:0]  x     [QW+1];
  logic [W-1:0]     mb    [QW+1];
  logic             ng    [QW+1];
  logic [SIDE_BITS-1:0] sd [QW+1];
  logic [QW:0]      vld;

  logic [W-1:0]  ma_in, mb_in;
  logic [QW-1:0] n_in;

  assign ma_in = f_mag(num);
  assign mb_in = f_mag(den);
  assign n_in  = {ma_in, {F{1'b0}}} + {{(F + 1){1'b0}}, mb_in[W-1:1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (ce) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x[0]  <= {{W{1'b0}}, n_in};
      mb[0] <= mb_in;
      ng[0] <= num[W-1] ^ den[W-1];
      sd[0] <= side_in;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [W:0]      rtop;
    logic [W:0]      rdif;
    logic            take;
    logic [W+QW-1:0] x_next;

    assign rtop   = x[k-1][W+QW-1:QW-1];
    assign rdif   = rtop - {1'b0, mb[k-1]};
    assign take   = rtop >= {1'b0, mb[k-1]};
    assign x_next = take ? {rdif[W-1:0], x[k-1][QW-2:0], 1'b1}
                         : {rtop[W-1:0], x[k-1][QW-2:0], 1'b0};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (ce) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        x[k]  <= x_next;
        mb[k] <= mb[k-1];
        ng[k] <= ng[k-1];
        sd[k] <= sd[k-1];
      end
    end
  end

  logic [QW-1:0] qmag;
  logic [W-1:0]  q_res;
  logic          q_sat;

  assign qmag = x[QW][QW-1:0];

  always_comb begin
    q_sat = 1'b0;
    q_res = '0;
    if (mb[QW] == '0) begin
      q_res = '0;
    end else if (!ng[QW]) begin
      if (qmag > LIM_P) begin
        q_sat = 1'b1;
        q_res = MAXV;
      end else begin
        q_res = qmag[W-1:0];
      end
    end else begin
      if (qmag > LIM_N) begin
        q_sat = 1'b1;
        q_res = MINV;
      end else begin
        q_res = ~qmag[W-1:0] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quo      <= q_res;
      sat      <= q_sat;
      side_out <= sd[QW];
    end
  end

endmodule

// ===== design/cubic_hermite_interpolator_core.sv =====
// cubic hermite interpolator top level: setup, horner evaluation, two dividers
// depends on chi_pkg and chi_div
// the pipeline depth (default format Q16.16) is set mainly by the two
// bit-per-stage dividers; throughput one request per cycle unless stalled
// the whole pipeline holds while out_stall is high and a result is waiting
// reset clears the valid bits only, datapath registers are not reset
module cubic_hermite_interpolator_core #(
  parameter int WORD_BITS = chi_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = chi_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] start_time,
  input  logic signed [WORD_BITS-1:0] end_time,
  input  logic signed [WORD_BITS-1:0] start_value,
  input  logic signed [WORD_BITS-1:0] end_value,
  input  logic signed [WORD_BITS-1:0] start_slope,
  input  logic signed [WORD_BITS-1:0] end_slope,
  input  logic signed [WORD_BITS-1:0] query_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] interp_value,
  output logic signed [WORD_BITS-1:0] interp_slope,
  output logic [1:0]                  status
);

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam int SIDE1 = 7 * W + 2;
  localparam int SIDE2 = W + 2;
  localparam logic signed [W-1:0] MAXV = {1'b0, {(W - 1){1'b1}}};
  localparam logic signed [W-1:0] MINV = {1'b1, {(W - 1){1'b0}}};
  localparam logic [2*W-F-1:0] LIM_P = {{(W - F + 1){1'b0}}, {(W - 1){1'b1}}};
  localparam logic [2*W-F-1:0] LIM_N = LIM_P + 1'b1;
  localparam logic [2*W-1:0] HALF = {{(2 * W - F){1'b0}}, 1'b1, {(F - 1){1'b0}}};

  typedef logic signed [W-1:0] word_t;
  typedef logic [2*W-1:0] prod_t;

  // results carry the saturation flag in the top bit
  function automatic logic [W:0] f_add(input word_t a, input word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? MINV : MAXV};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] f_sub(input word_t a, input word_t b);
    logic signed [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    if (s[W] != s[W-1]) return {1'b1, s[W] ? MINV : MAXV};
    return {1'b0, s[W-1:0]};
  endfunction

  function automatic logic [W:0] f_thrice(input word_t a);
    logic [W:0] t;
    logic [W:0] u;
    t = f_add(a, a);
    u = f_add(t[W-1:0], a);
    return {t[W] | u[W], u[W-1:0]};
  endfunction

  function automatic logic [W-1:0] f_mag(input word_t a);
    return a[W-1] ? (~a + 1'b1) : a;
  endfunction

  function automatic prod_t f_mul(input word_t a, input word_t b);
    return {{W{1'b0}}, f_mag(a)} * {{W{1'b0}}, f_mag(b)};
  endfunction

  // round magnitude half away from zero, apply sign, clamp
  function automatic logic [W:0] f_round(input logic neg, input prod_t p);
    prod_t r;
    logic [2*W-F-1:0] m;
    r = p + HALF;
    m = r[2*W-1:F];
    if (!neg) begin
      if (m > LIM_P) return {1'b1, MAXV};
      return {1'b0, m[W-1:0]};
    end
    if (m > LIM_N) return {1'b1, MINV};
    return {1'b0, ~m[W-1:0] + 1'b1};
  endfunction

  logic ce;
  assign ce       = !out_valid || !out_stall;
  assign in_stall = !ce;

  logic [8:1] va;
  logic [9:1] vh;
  logic       d1_valid, d2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      va        <= '0;
      vh        <= '0;
      out_valid <= 1'b0;
    end else if (ce) begin
      va        <= {va[7:1], in_valid};
      vh        <= {vh[8:1], d1_valid};
      out_valid <= d2_valid;
    end
  end

  // setup stages
  word_t s1_dt, s1_dq, s1_x0, s1_x1, s1_v0, s1_v1;
  logic  s1_zero, s1_sat;
  prod_t s2_pr0, s2_pr1;
  logic  s2_ng0, s2_ng1, s2_zero, s2_sat;
  word_t s2_dt, s2_dq, s2_x0, s2_x1;
  word_t s3_p0, s3_p1, s3_dt, s3_dq, s3_x0, s3_x1;
  logic  s3_zero, s3_sat;
  word_t s4_t3x1, s4_t3x0, s4_t2x0, s4_t2x1, s4_t2p0, s4_p0, s4_p1, s4_x0, s4_dt, s4_dq;
  logic  s4_zero, s4_sat;
  word_t s5_a, s5_b, s5_t2p0, s5_p0, s5_p1, s5_x0, s5_dt, s5_dq;
  logic  s5_zero, s5_sat;
  word_t s6_c2a, s6_c3a, s6_p1, s6_p0, s6_x0, s6_dt, s6_dq;
  logic  s6_zero, s6_sat;
  word_t s7_c2, s7_c3, s7_p0, s7_x0, s7_dt, s7_dq;
  logic  s7_zero, s7_sat;
  word_t s8_t2c2, s8_t3c3, s8_c2, s8_c3, s8_p0, s8_x0, s8_dt, s8_dq;
  logic  s8_zero, s8_sat;

  logic [W:0] r_dt, r_dq, r_p0, r_p1;
  logic [W:0] r_t3x1, r_t3x0, r_t2x0, r_t2x1, r_t2p0;
  logic [W:0] r_a, r_b, r_c2a, r_c3a, r_c2, r_c3, r_t2c2, r_t3c3;

  assign r_dt   = f_sub(end_time, start_time);
  assign r_dq   = f_sub(query_time, start_time);
  assign r_p0   = f_round(s2_ng0, s2_pr0);
  assign r_p1   = f_round(s2_ng1, s2_pr1);
  assign r_t3x1 = f_thrice(s3_x1);
  assign r_t3x0 = f_thrice(s3_x0);
  assign r_t2x0 = f_add(s3_x0, s3_x0);
  assign r_t2x1 = f_add(s3_x1, s3_x1);
  assign r_t2p0 = f_add(s3_p0, s3_p0);
  assign r_a    = f_sub(s4_t3x1, s4_t3x0);
  assign r_b    = f_sub(s4_t2x0, s4_t2x1);
  assign r_c2a  = f_sub(s5_a, s5_t2p0);
  assign r_c3a  = f_add(s5_b, s5_p0);
  assign r_c2   = f_sub(s6_c2a, s6_p1);
  assign r_c3   = f_add(s6_c3a, s6_p1);
  assign r_t2c2 = f_add(s7_c2, s7_c2);
  assign r_t3c3 = f_thrice(s7_c3);

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_dt   <= r_dt[W-1:0];
      s1_dq   <= r_dq[W-1:0];
      s1_x0   <= start_value;
      s1_x1   <= end_value;
      s1_v0   <= start_slope;
      s1_v1   <= end_slope;
      s1_zero <= start_time == end_time;
      s1_sat  <= r_dt[W] | r_dq[W];

      s2_pr0  <= f_mul(s1_v0, s1_dt);
      s2_pr1  <= f_mul(s1_v1, s1_dt);
      s2_ng0  <= s1_v0[W-1] ^ s1_dt[W-1];
      s2_ng1  <= s1_v1[W-1] ^ s1_dt[W-1];
      s2_dt   <= s1_dt;
      s2_dq   <= s1_dq;
      s2_x0   <= s1_x0;
      s2_x1   <= s1_x1;
      s2_zero <= s1_zero;
      s2_sat  <= s1_sat;

      s3_p0   <= r_p0[W-1:0];
      s3_p1   <= r_p1[W-1:0];
      s3_dt   <= s2_dt;
      s3_dq   <= s2_dq;
      s3_x0   <= s2_x0;
      s3_x1   <= s2_x1;
      s3_zero <= s2_zero;
      s3_sat  <= s2_sat | r_p0[W] | r_p1[W];

      s4_t3x1 <= r_t3x1[W-1:0];
      s4_t3x0 <= r_t3x0[W-1:0];
      s4_t2x0 <= r_t2x0[W-1:0];
      s4_t2x1 <= r_t2x1[W-1:0];
      s4_t2p0 <= r_t2p0[W-1:0];
      s4_p0   <= s3_p0;
      s4_p1   <= s3_p1;
      s4_x0   <= s3_x0;
      s4_dt   <= s3_dt;
      s4_dq   <= s3_dq;
      s4_zero <= s3_zero;
      s4_sat  <= s3_sat | r_t3x1[W] | r_t3x0[W] | r_t2x0[W] | r_t2x1[W] | r_t2p0[W];

      s5_a    <= r_a[W-1:0];
      s5_b    <= r_b[W-1:0];
      s5_t2p0 <= s4_t2p0;
      s5_p0   <= s4_p0;
      s5_p1   <= s4_p1;
      s5_x0   <= s4_x0;
      s5_dt   <= s4_dt;
      s5_dq   <= s4_dq;
      s5_zero <= s4_zero;
      s5_sat  <= s4_sat | r_a[W] | r_b[W];

      s6_c2a  <= r_c2a[W-1:0];
      s6_c3a  <= r_c3a[W-1:0];
      s6_p1   <= s5_p1;
      s6_p0   <= s5_p0;
      s6_x0   <= s5_x0;
      s6_dt   <= s5_dt;
      s6_dq   <= s5_dq;
      s6_zero <= s5_zero;
      s6_sat  <= s5_sat | r_c2a[W] | r_c3a[W];

      s7_c2   <= r_c2[W-1:0];
      s7_c3   <= r_c3[W-1:0];
      s7_p0   <= s6_p0;
      s7_x0   <= s6_x0;
      s7_dt   <= s6_dt;
      s7_dq   <= s6_dq;
      s7_zero <= s6_zero;
      s7_sat  <= s6_sat | r_c2[W] | r_c3[W];

      s8_t2c2 <= r_t2c2[W-1:0];
      s8_t3c3 <= r_t3c3[W-1:0];
      s8_c2   <= s7_c2;
      s8_c3   <= s7_c3;
      s8_p0   <= s7_p0;
      s8_x0   <= s7_x0;
      s8_dt   <= s7_dt;
      s8_dq   <= s7_dq;
      s8_zero <= s7_zero;
      s8_sat  <= s7_sat | r_t2c2[W] | r_t3c3[W];
    end
  end

  // normalized position lam = dq / dt
  word_t d1_lam, d1_x0, d1_p0, d1_c2, d1_c3, d1_t2c2, d1_t3c3, d1_dt;
  logic  d1_lsat, d1_zero, d1_sat;
  logic [SIDE1-1:0] d1_side;

  assign {d1_zero, d1_sat, d1_x0, d1_p0, d1_c2, d1_c3, d1_t2c2, d1_t3c3, d1_dt} = d1_side;

  chi_div #(
    .WORD_BITS (W),
    .FRAC_BITS (F),
    .SIDE_BITS (SIDE1)
  ) u_div_lam (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (va[8]),
    .num       (s8_dq),
    .den       (s8_dt),
    .side_in   ({s8_zero, s8_sat, s8_x0, s8_p0, s8_c2, s8_c3, s8_t2c2, s8_t3c3, s8_dt}),
    .out_valid (d1_valid),
    .quo       (d1_lam),
    .sat       (d1_lsat),
    .side_out  (d1_side)
  );

  // horner evaluation of value and derivative numerator
  prod_t h1_pa, h1_pb;
  logic  h1_na, h1_nb, h1_zero, h1_sat;
  word_t h1_lam, h1_x0, h1_p0, h1_c2, h1_t2c2, h1_dt;
  word_t h2_m1, h2_n1, h2_lam, h2_x0, h2_p0, h2_c2, h2_t2c2, h2_dt;
  logic  h2_zero, h2_sat;
  word_t h3_v1, h3_d1, h3_lam, h3_x0, h3_p0, h3_dt;
  logic  h3_zero, h3_sat;
  prod_t h4_pa, h4_pb;
  logic  h4_na, h4_nb, h4_zero, h4_sat;
  word_t h4_lam, h4_x0, h4_p0, h4_dt;
  word_t h5_m2, h5_n2, h5_lam, h5_x0, h5_p0, h5_dt;
  logic  h5_zero, h5_sat;
  word_t h6_v2, h6_d2, h6_lam, h6_x0, h6_dt;
  logic  h6_zero, h6_sat;
  prod_t h7_pa;
  logic  h7_na, h7_zero, h7_sat;
  word_t h7_x0, h7_d2, h7_dt;
  word_t h8_m3, h8_x0, h8_d2, h8_dt;
  logic  h8_zero, h8_sat;
  word_t h9_val, h9_d2, h9_dt;
  logic  h9_zero, h9_sat;

  logic [W:0] r_m1, r_n1, r_v1, r_d1, r_m2, r_n2, r_v2, r_d2, r_m3, r_val;

  assign r_m1  = f_round(h1_na, h1_pa);
  assign r_n1  = f_round(h1_nb, h1_pb);
  assign r_v1  = f_add(h2_c2, h2_m1);
  assign r_d1  = f_add(h2_t2c2, h2_n1);
  assign r_m2  = f_round(h4_na, h4_pa);
  assign r_n2  = f_round(h4_nb, h4_pb);
  assign r_v2  = f_add(h5_p0, h5_m2);
  assign r_d2  = f_add(h5_p0, h5_n2);
  assign r_m3  = f_round(h7_na, h7_pa);
  assign r_val = f_add(h8_x0, h8_m3);

  always_ff @(posedge clk) begin
    if (ce) begin
      h1_pa   <= f_mul(d1_lam, d1_c3);
      h1_pb   <= f_mul(d1_lam, d1_t3c3);
      h1_na   <= d1_lam[W-1] ^ d1_c3[W-1];
      h1_nb   <= d1_lam[W-1] ^ d1_t3c3[W-1];
      h1_lam  <= d1_lam;
      h1_x0   <= d1_x0;
      h1_p0   <= d1_p0;
      h1_c2   <= d1_c2;
      h1_t2c2 <= d1_t2c2;
      h1_dt   <= d1_dt;
      h1_zero <= d1_zero;
      h1_sat  <= d1_sat | d1_lsat;

      h2_m1   <= r_m1[W-1:0];
      h2_n1   <= r_n1[W-1:0];
      h2_lam  <= h1_lam;
      h2_x0   <= h1_x0;
      h2_p0   <= h1_p0;
      h2_c2   <= h1_c2;
      h2_t2c2 <= h1_t2c2;
      h2_dt   <= h1_dt;
      h2_zero <= h1_zero;
      h2_sat  <= h1_sat | r_m1[W] | r_n1[W];

      h3_v1   <= r_v1[W-1:0];
      h3_d1   <= r_d1[W-1:0];
      h3_lam  <= h2_lam;
      h3_x0   <= h2_x0;
      h3_p0   <= h2_p0;
      h3_dt   <= h2_dt;
      h3_zero <= h2_zero;
      h3_sat  <= h2_sat | r_v1[W] | r_d1[W];

      h4_pa   <= f_mul(h3_lam, h3_v1);
      h4_pb   <= f_mul(h3_lam, h3_d1);
      h4_na   <= h3_lam[W-1] ^ h3_v1[W-1];
      h4_nb   <= h3_lam[W-1] ^ h3_d1[W-1];
      h4_lam  <= h3_lam;
      h4_x0   <= h3_x0;
      h4_p0   <= h3_p0;
      h4_dt   <= h3_dt;
      h4_zero <= h3_zero;
      h4_sat  <= h3_sat;

      h5_m2   <= r_m2[W-1:0];
      h5_n2   <= r_n2[W-1:0];
      h5_lam  <= h4_lam;
      h5_x0   <= h4_x0;
      h5_p0   <= h4_p0;
      h5_dt   <= h4_dt;
      h5_zero <= h4_zero;
      h5_sat  <= h4_sat | r_m2[W] | r_n2[W];

      h6_v2   <= r_v2[W-1:0];
      h6_d2   <= r_d2[W-1:0];
      h6_lam  <= h5_lam;
      h6_x0   <= h5_x0;
      h6_dt   <= h5_dt;
      h6_zero <= h5_zero;
      h6_sat  <= h5_sat | r_v2[W] | r_d2[W];

      h7_pa   <= f_mul(h6_lam, h6_v2);
      h7_na   <= h6_lam[W-1] ^ h6_v2[W-1];
      h7_x0   <= h6_x0;
      h7_d2   <= h6_d2;
      h7_dt   <= h6_dt;
      h7_zero <= h6_zero;
      h7_sat  <= h6_sat;

      h8_m3   <= r_m3[W-1:0];
      h8_x0   <= h7_x0;
      h8_d2   <= h7_d2;
      h8_dt   <= h7_dt;
      h8_zero <= h7_zero;
      h8_sat  <= h7_sat | r_m3[W];

      h9_val  <= r_val[W-1:0];
      h9_d2   <= h8_d2;
      h9_dt   <= h8_dt;
      h9_zero <= h8_zero;
      h9_sat  <= h8_sat | r_val[W];
    end
  end

  // derivative = horner numerator / dt
  word_t d2_der, d2_val;
  logic  d2_dsat, d2_zero, d2_sat;
  logic [SIDE2-1:0] d2_side;

  assign {d2_zero, d2_sat, d2_val} = d2_side;

  chi_div #(
    .WORD_BITS (W),
    .FRAC_BITS (F),
    .SIDE_BITS (SIDE2)
  ) u_div_der (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (vh[9]),
    .num       (h9_d2),
    .den       (h9_dt),
    .side_in   ({h9_zero, h9_sat, h9_val}),
    .out_valid (d2_valid),
    .quo       (d2_der),
    .sat       (d2_dsat),
    .side_out  (d2_side)
  );

  chi_pkg::status_t out_st;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (d2_zero) begin
        interp_value <= '0;
        interp_slope <= '0;
        out_st       <= chi_pkg::STATUS_ZERO_SPAN;
      end else begin
        interp_value <= d2_val;
        interp_slope <= d2_der;
        out_st       <= (d2_sat || d2_dsat) ? chi_pkg::STATUS_SAT : chi_pkg::STATUS_OK;
      end
    end
  end

  assign status = out_st;

  a_zero_span_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_st == chi_pkg::STATUS_ZERO_SPAN |-> interp_value == '0 && interp_slope == '0)
    else $error("zero-length interval gave nonzero result");

  a_hold_valids : assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(va) && $stable(vh) && $stable(out_valid))
    else $error("pipeline valid bits moved during stall");

  a_reset_empty : assert property (@(posedge clk)
    rst |=> !out_valid && va == '0 && vh == '0)
    else $error("pipeline not empty after reset");

  a_hold_result : assert property (@(posedge clk) disable iff (rst)
    !ce |=> $stable(out_st) && $stable(interp_slope))
    else $error("result register changed while held");

endmodule

// ===== tb/sv/chi_checker.sv =====
// request/result checker for cubic_hermite_interpolator_core: predicts each result
// in Q16.16 and compares it with the block's output; depends on chi_pkg
module chi_checker #(
  parameter int WORD_BITS = chi_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = chi_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic signed [WORD_BITS-1:0] start_time,
  input  logic signed [WORD_BITS-1:0] end_time,
  input  logic signed [WORD_BITS-1:0] start_value,
  input  logic signed [WORD_BITS-1:0] end_value,
  input  logic signed [WORD_BITS-1:0] start_slope,
  input  logic signed [WORD_BITS-1:0] end_slope,
  input  logic signed [WORD_BITS-1:0] query_time,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic signed [WORD_BITS-1:0] interp_value,
  input  logic signed [WORD_BITS-1:0] interp_slope,
  input  logic [1:0]                  status,
  output int                          errors,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [WORD_BITS-1:0] value;
    logic signed [WORD_BITS-1:0] slope;
    chi_pkg::status_t            st;
  } interp_t;

  localparam longint WMAX = (64'sd1 <<< (WORD_BITS - 1)) - 1;
  localparam longint WMIN = -WMAX - 1;

  interp_t interp_q[$];
  bit      clipped;

  initial errors = 0;
  assign pending = interp_q.size();

  function automatic longint clip(longint v);
    if (v > WMAX) begin
      clipped = 1;
      return WMAX;
    end
    if (v < WMIN) begin
      clipped = 1;
      return WMIN;
    end
    return v;
  endfunction

  // magnitude plus sign back to a clamped word
  function automatic longint signed_mag(bit neg, longint mag);
    if (!neg) return (mag > WMAX) ? clip(mag) : mag;
    return (mag > WMAX + 1) ? clip(-mag) : -mag;
  endfunction

  function automatic longint add(longint a, longint b);
    return clip(a + b);
  endfunction

  function automatic longint sub(longint a, longint b);
    return clip(a - b);
  endfunction

  // magnitude rounded half away from zero
  function automatic longint mul(longint a, longint b);
    longint p, m;
    p = a * b;
    m = (p < 0) ? -p : p;
    m = (m + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    return signed_mag((a < 0) != (b < 0), m);
  endfunction

  function automatic longint div(longint a, longint b);
    longint ma, mb, q;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    if (mb == 0) return 0;
    q = ((ma <<< FRAC_BITS) + (mb >>> 1)) / mb;
    return signed_mag((a < 0) != (b < 0), q);
  endfunction

  function automatic interp_t hermite(longint t0, longint t1, longint x0, longint x1,
                                      longint v0, longint v1, longint tq);
    interp_t r;
    longint dt, lam, p0, p1, c2, c3, val, der;
    clipped = 0;
    dt = sub(t1, t0);
    if (dt == 0) begin
      r.value = '0;
      r.slope = '0;
      r.st = chi_pkg::STATUS_ZERO_SPAN;
      return r;
    end
    lam = div(sub(tq, t0), dt);
    p0 = mul(v0, dt);
    p1 = mul(v1, dt);
    c2 = sub(add(add(x1, x1), x1), add(add(x0, x0), x0));
    c2 = sub(c2, add(p0, p0));
    c2 = sub(c2, p1);
    c3 = sub(add(x0, x0), add(x1, x1));
    c3 = add(c3, p0);
    c3 = add(c3, p1);
    val = add(c2, mul(lam, c3));
    val = add(p0, mul(lam, val));
    val = add(x0, mul(lam, val));
    der = add(add(c2, c2), mul(lam, add(add(c3, c3), c3)));
    der = add(p0, mul(lam, der));
    der = div(der, dt);
    r.value = val[WORD_BITS-1:0];
    r.slope = der[WORD_BITS-1:0];
    r.st = clipped ? chi_pkg::STATUS_SAT : chi_pkg::STATUS_OK;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    interp_t want;
    if (!rst) begin
      if (in_valid && !in_stall)
        interp_q.push_back(hermite(start_time, end_time, start_value, end_value,
                                   start_slope, end_slope, query_time));
      if (out_valid && !out_stall) begin
        if (interp_q.size() == 0) begin
          report("unexpected result", 1, 0);
        end else begin
          want = interp_q.pop_front();
          if (interp_value !== want.value) report("interp_value", interp_value, want.value);
          if (interp_slope !== want.slope) report("interp_slope", interp_slope, want.slope);
          if (status !== want.st) report("status", status, want.st);
        end
      end
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the cubic_hermite_interpolator_core testbench: clock, reset, request
// stimulus, output stalls and verdict; depends on chi_pkg and chi_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = chi_pkg::WORD_BITS_DEF;
  localparam int WATCH_LIMIT = 20000;
  localparam int LONG_HOLD = 400;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [W-1:0] start_time = 0, end_time = 0, start_value = 0, end_value = 0;
  logic signed [W-1:0] start_slope = 0, end_slope = 0, query_time = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [W-1:0] interp_value, interp_slope;
  logic [1:0] status;
  int errors, pending;
  int hold_req = 0;
  int idle_cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  cubic_hermite_interpolator_core dut (.*);

  chi_checker chk (.*);

  task automatic send(logic signed [W-1:0] t0, t1, x0, x1, v0, v1, tq);
    start_time <= t0;
    end_time <= t1;
    start_value <= x0;
    end_value <= x1;
    start_slope <= v0;
    end_slope <= v1;
    query_time <= tq;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
  endtask

  // mostly modest intervals so the polynomial stays in range, some raw noise
  task automatic send_random();
    logic signed [W-1:0] t0, dt;
    if ($urandom_range(0, 9) < 3) begin
      send($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      t0 = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
      dt = $signed($urandom_range(1, 32'h0008_0000));
      if ($urandom_range(0, 3) == 0) dt = -dt;
      send(t0, t0 + dt,
           $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000,
           $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000,
           $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
           $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000,
           t0 + $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0001_0000);
    end
  endtask

  // receiver: random stall segments plus a long hold-off on request
  initial begin
    int hold_done, mode;
    hold_done = 0;
    forever begin
      if (hold_req != hold_done) begin
        hold_done = hold_req;
        out_stall <= 1;
        repeat (LONG_HOLD) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(8, 80)) begin
        case (mode)
          0: out_stall <= 0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= $urandom_range(0, 1);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int n;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // zero-length interval, including the extremes
    send(32'sh0001_0000, 32'sh0001_0000, 5, 6, 7, 8, 9);
    send(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 1, -1, 0);
    // unit interval: linear data queried at both ends, other data queried in the middle
    send(0, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000, 0);
    send(0, 32'sh0001_0000, 0, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
         32'sh0001_0000);
    send(0, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000, 32'sh0000_8000,
         -32'sh0001_8000, 32'sh0000_8000);
    // reversed interval and extrapolation on both sides
    send(32'sh0002_0000, 0, 32'sh0001_0000, -32'sh0001_0000, 0, 32'sh0004_0000,
         32'sh0005_0000);
    send(0, 32'sh0000_4000, 32'sh0001_0000, 0, 32'sh0002_0000, 0, -32'sh0003_0000);
    // tiny interval so the normalized position blows up
    send(0, 1, 0, 32'sh0001_0000, 0, 0, 32'sh0010_0000);
    // interval length overflows the word
    send(32'sh8000_0000, 32'sh7fff_ffff, 0, 0, 0, 0, 0);
    send(32'sh7fff_ffff, 32'sh8000_0000, 1, 2, 3, 4, 5);
    // extreme values and slopes
    send(0, 32'sh0001_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
         32'sh8000_0000, 32'sh0000_8000);
    send(0, 32'sh0001_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
         32'sh7fff_ffff, 32'sh7fff_ffff);
    send(-1, 32'sh7fff_ffff, -1, -1, -1, -1, 32'sh8000_0000);
    send(32'sh8000_0000, -1, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
         32'sh8000_0000, 32'sh8000_0000);
    // rounding ties on small products
    send(0, 32'sh0000_0002, 1, -1, 32'sh0000_8000, -32'sh0000_8000, 1);
    in_valid <= 0;
    // wait for the whole pipeline to drain before going random
    while (pending != 0) @(posedge clk);
    @(posedge clk);

    n = 0;
    while (n < 1250) begin
      repeat ($urandom_range(1, 40)) begin
        send_random();
        n++;
        if (n == 300) hold_req <= hold_req + 1;
      end
      if (n > 700 && n < 760) begin
        in_valid <= 0;
        while (pending != 0) @(posedge clk);
      end else if ($urandom_range(0, 2) != 0) begin
        in_valid <= 0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    in_valid <= 0;

    while (pending != 0) @(posedge clk);
    repeat (130) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
